FILE: rtl/fvcw_pkg.sv
// Shared types and constant tables for the flow vector color wheel.
// Holds the arctangent table, the 55-entry color wheel and the cell payload type.
// No dependencies.
package fvcw_pkg;

	localparam int unsigned CORDIC_ITERS = 20;
	localparam int unsigned DIV_CELLS    = 33;
	localparam int unsigned SQRT_CELLS   = 17;
	localparam int unsigned NCELLS       = DIV_CELLS + SQRT_CELLS;
	localparam int unsigned NCOLS        = 55;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [23:0] WHITE_C   = 24'd16711680;  // 255 * 65536

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
	};

	// perceptual color wheel, one array per channel
	localparam logic [7:0] WHEEL_R [NCOLS] = '{
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43,
		8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176,
		8'd196, 8'd215, 8'd235,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};
	localparam logic [7:0] WHEEL_G [NCOLS] = '{
		8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119, 8'd136, 8'd153,
		8'd170, 8'd187, 8'd204, 8'd221, 8'd238,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd232, 8'd209, 8'd186, 8'd163, 8'd140, 8'd116, 8'd93, 8'd70, 8'd47,
		8'd24,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
	};
	localparam logic [7:0] WHEEL_B [NCOLS] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd63, 8'd127, 8'd191,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255,
		8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43
	};

	// payload handed from cell to cell
	typedef struct packed {
		logic               ok;      // vector usable
		logic               in_rad;  // radius at most one
		logic               axis;    // vector on the x axis
		logic               xneg;    // x below zero
		logic signed [35:0] cx;
		logic signed [35:0] cy;
		logic [31:0]        cz;
		logic [31:0]        drem;    // divider remainder
		logic [31:0]        dden;    // divider denominator
		logic [32:0]        dq;      // divider quotient
		logic [19:0]        srem;    // root remainder
		logic [16:0]        sroot;   // root so far
		logic [33:0]        srad;    // radicand bits still to enter
	} cell_t;

endpackage

FILE: rtl/fvcw_cell.sv
// One cell of the processing chain: a divider bit or a root bit, with a CORDIC rotation in the early cells as well.
// The work done is fixed by the cell's place in the chain.
// Depends on fvcw_pkg.
module fvcw_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  fvcw_pkg::cell_t d,
	output logic           vld_q,
	output fvcw_pkg::cell_t d_q
);
	import fvcw_pkg::*;

	logic signed [35:0] cx_n, cy_n;
	logic [31:0]        cz_n;
	logic [31:0]        drem_n;
	logic [32:0]        dq_n;
	logic [19:0]        srem_n;
	logic [16:0]        sroot_n;
	logic [33:0]        srad_n;
	cell_t              nxt;

	// rotate toward the x axis
	if (IDX < CORDIC_ITERS) begin : g_cordic
		logic signed [35:0] xs, ys;
		assign xs = d.cx >>> IDX;
		assign ys = d.cy >>> IDX;
		always_comb begin
			if (d.cy > 0) begin
				cx_n = d.cx + ys;
				cy_n = d.cy - xs;
				cz_n = d.cz + ATAN_TURNS[IDX];
			end else begin
				cx_n = d.cx - ys;
				cy_n = d.cy + xs;
				cz_n = d.cz - ATAN_TURNS[IDX];
			end
		end
	end else begin : g_no_cordic
		assign cx_n = d.cx;
		assign cy_n = d.cy;
		assign cz_n = d.cz;
	end

	// one restoring divider step
	if (IDX < DIV_CELLS) begin : g_div
		logic [32:0] rr;
		logic        ge;
		if (IDX == 0) begin : g_first
			assign rr = {1'b0, d.drem};
		end else begin : g_next
			assign rr = {d.drem, 1'b0};
		end
		assign ge     = rr >= {1'b0, d.dden};
		assign drem_n = ge ? 32'(rr - {1'b0, d.dden}) : rr[31:0];
		assign dq_n   = {d.dq[31:0], ge};
	end else begin : g_no_div
		assign drem_n = d.drem;
		assign dq_n   = d.dq;
	end

	// one digit-by-digit root step
	if (IDX >= DIV_CELLS) begin : g_sqrt
		logic [33:0] rad;
		logic [19:0] remi, remw, trial;
		logic [16:0] rooti;
		logic        ge;
		if (IDX == DIV_CELLS) begin : g_first
			assign rad   = {1'b0, d.dq};
			assign remi  = '0;
			assign rooti = '0;
		end else begin : g_next
			assign rad   = d.srad;
			assign remi  = d.srem;
			assign rooti = d.sroot;
		end
		assign remw    = {remi[17:0], rad[33:32]};
		assign trial   = {1'b0, rooti, 2'b01};
		assign ge      = remw >= trial;
		assign srem_n  = ge ? remw - trial : remw;
		assign sroot_n = {rooti[15:0], ge};
		assign srad_n  = {rad[31:0], 2'b00};
	end else begin : g_no_sqrt
		assign srem_n  = d.srem;
		assign sroot_n = d.sroot;
		assign srad_n  = d.srad;
	end

	always_comb begin
		nxt       = d;
		nxt.cx    = cx_n;
		nxt.cy    = cy_n;
		nxt.cz    = cz_n;
		nxt.drem  = drem_n;
		nxt.dq    = dq_n;
		nxt.srem  = srem_n;
		nxt.sroot = sroot_n;
		nxt.srad  = srad_n;
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule

FILE: rtl/fvcw_color.sv
// Color stage: wheel position, blend of two wheel entries and radius shading.
// Five pipeline stages behind the cell chain.
// Depends on fvcw_pkg.
module fvcw_color (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  fvcw_pkg::cell_t d,
	output logic            vld_s5,
	output logic [2:0][7:0] rgb_s5
);
	import fvcw_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [37:0] p_s1;
	logic        ok_s1, in_s1;
	logic [16:0] r_s1;
	logic [31:0] phi;

	logic [2:0][23:0] pa_s2, pb_s2;
	logic             ok_s2, in_s2;
	logic [16:0]      r_s2;
	logic [5:0]       k0, k1;
	logic [15:0]      f;
	logic [16:0]      fi;
	logic [2:0][7:0]  c0, c1;

	logic [2:0][23:0] c_s3, dd_s3;
	logic             ok_s3, in_s3;
	logic [16:0]      r_s3;

	logic [2:0][40:0] t_s4;
	logic [2:0][7:0]  o_s4;
	logic             ok_s4, in_s4;

	// pick the direction, with the axis cases exact
	always_comb begin
		if (d.axis) begin
			phi = d.xneg ? HALF_TURN : '0;
		end else begin
			phi = d.cz;
		end
	end

	assign k0 = p_s1[37:32];
	assign k1 = k0 + 6'd1;
	assign f  = p_s1[31:16];
	assign fi = 17'd65536 - {1'b0, f};
	assign c0 = {WHEEL_B[k0], WHEEL_G[k0], WHEEL_R[k0]};
	assign c1 = {WHEEL_B[k1], WHEEL_G[k1], WHEEL_R[k1]};

	// advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// wheel position
			p_s1  <= 38'(phi) * 38'd54;
			ok_s1 <= d.ok;
			in_s1 <= d.in_rad;
			r_s1  <= d.sroot;
			// weighted entries
			for (int ch = 0; ch < 3; ch++) begin
				pa_s2[ch] <= 24'(c0[ch]) * 24'(fi);
				pb_s2[ch] <= 24'(c1[ch]) * 24'(f);
			end
			ok_s2 <= ok_s1;
			in_s2 <= in_s1;
			r_s2  <= r_s1;
			// blend and distance to white
			for (int ch = 0; ch < 3; ch++) begin
				c_s3[ch]  <= pa_s2[ch] + pb_s2[ch];
				dd_s3[ch] <= WHITE_C - (pa_s2[ch] + pb_s2[ch]);
			end
			ok_s3 <= ok_s2;
			in_s3 <= in_s2;
			r_s3  <= r_s2;
			// radius shading products and the dimmed color
			for (int ch = 0; ch < 3; ch++) begin
				t_s4[ch] <= 41'(r_s3) * 41'(dd_s3[ch]);
				o_s4[ch] <= 8'(({2'b00, c_s3[ch]} + {1'b0, c_s3[ch], 1'b0}) >> 18);
			end
			ok_s4 <= ok_s3;
			in_s4 <= in_s3;
			// final channel values
			for (int ch = 0; ch < 3; ch++) begin
				if (!ok_s4) begin
					rgb_s5[ch] <= '0;
				end else if (in_s4) begin
					rgb_s5[ch] <= 8'd255 - 8'(({1'b0, t_s4[ch]} + 42'h0_FFFF_FFFF) >> 32);
				end else begin
					rgb_s5[ch] <= o_s4[ch];
				end
			end
		end
	end

endmodule

FILE: rtl/flow_vector_color_wheel_core.sv
// Top level of the flow vector color wheel: input stages, cell chain, color stage, skid.
// Depends on fvcw_pkg, fvcw_cell and fvcw_color.
//
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_data = max_motion (zero acts as one).
//   Write it only while the block is idle; cfg_ready is always high.
//   in channel: in_valid/in_ready with flow_x, flow_y, flow_valid, one vector
//   per transfer. out channel: out_valid/out_ready with red, green, blue.
//   Throughput: one vector per cycle while the skid buffer is empty. Path from input
//   transfer to out_valid: two input stages, 50 chain cells, five color stages. The chain
//   length is set by the 33-bit radius divide plus the 17-bit square root;
//   the 20 CORDIC rotations run in the first cells alongside the divide.
//   Reset: all stage valids clear, max_motion returns to 256, no output pending.
//   Stall: a result the receiver does not take moves into a one-entry skid
//   buffer; in_ready drops only while that buffer is full, and the whole
//   pipeline holds with it.
module flow_vector_color_wheel_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] flow_x,
	input  logic signed [15:0] flow_y,
	input  logic        flow_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import fvcw_pkg::*;

	logic [15:0] max_motion_q;
	logic [15:0] m_eff;
	logic        en;

	logic        vld_s1, vld_s2;
	logic [30:0] xx_s1, yy_s1;
	logic [31:0] mm_s1;
	logic        ok_s1, axis_s1, xneg_s1;
	logic signed [35:0] cx_s1, cy_s1;
	logic [31:0] cz_s1;

	logic [31:0] s_s2, mm_s2;
	logic        ok_s2, in_s2, axis_s2, xneg_s2;
	logic signed [35:0] cx_s2, cy_s2;
	logic [31:0] cz_s2;

	logic signed [35:0] xe, ye;
	logic [31:0]        s_sum;

	logic  cv   [NCELLS+1];
	cell_t cd   [NCELLS+1];

	logic            cvld;
	logic [2:0][7:0] crgb;
	logic            skid_vld_q;
	logic [2:0][7:0] skid_q;
	logic [2:0][7:0] rgb;

	assign cfg_ready = 1'b1;
	assign en        = !skid_vld_q;
	assign in_ready  = en;
	assign m_eff     = (max_motion_q == '0) ? 16'd1 : max_motion_q;

	// hold the normalizing radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_motion_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			max_motion_q <= cfg_data;
		end
	end

	// fold the left half plane onto the right, scale by 2^16
	always_comb begin
		xe = 36'(flow_x);
		ye = 36'(flow_y);
		if (flow_x < 0) begin
			xe = -xe;
			ye = -ye;
		end
	end

	assign s_sum = {1'b0, xx_s1} + {1'b0, yy_s1};

	// advance input stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// squares, then radius test
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1   <= 31'(32'(flow_x) * 32'(flow_x));
			yy_s1   <= 31'(32'(flow_y) * 32'(flow_y));
			mm_s1   <= 32'(m_eff) * 32'(m_eff);
			ok_s1   <= flow_valid;
			axis_s1 <= (flow_y == 16'sd0);
			xneg_s1 <= (flow_x < 0);
			cx_s1   <= xe <<< 16;
			cy_s1   <= ye <<< 16;
			cz_s1   <= (flow_x < 0) ? HALF_TURN : '0;

			s_s2    <= s_sum;
			mm_s2   <= mm_s1;
			in_s2   <= s_sum <= mm_s1;
			ok_s2   <= ok_s1;
			axis_s2 <= axis_s1;
			xneg_s2 <= xneg_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			cz_s2   <= cz_s1;
		end
	end

	// load the head of the chain
	always_comb begin
		cv[0]        = vld_s2;
		cd[0]        = '0;
		cd[0].ok     = ok_s2;
		cd[0].in_rad = in_s2;
		cd[0].axis   = axis_s2;
		cd[0].xneg   = xneg_s2;
		cd[0].cx     = cx_s2;
		cd[0].cy     = cy_s2;
		cd[0].cz     = cz_s2;
		cd[0].drem   = s_s2;
		cd[0].dden   = mm_s2;
	end

	for (genvar g = 0; g < NCELLS; g++) begin : g_chain
		fvcw_cell #(
			.IDX(g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (cv[g]),
			.d     (cd[g]),
			.vld_q (cv[g+1]),
			.d_q   (cd[g+1])
		);
	end

	fvcw_color u_color (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (cv[NCELLS]),
		.d     (cd[NCELLS]),
		.vld_s5(cvld),
		.rgb_s5(crgb)
	);

	// catch a result the receiver stalls on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (cvld && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && cvld && !out_ready) begin
			skid_q <= crgb;
		end
	end

	assign out_valid = skid_vld_q || cvld;
	assign rgb       = skid_vld_q ? skid_q : crgb;
	assign red       = rgb[0];
	assign green     = rgb[1];
	assign blue      = rgb[2];

endmodule

FILE: test/flow_vector_color_wheel_core_test.sv
// Testbench for the flow vector color wheel core: drives flow vectors and max_motion writes,
// predicts each RGB color and checks it against the block output in order.
// Depends on fvcw_pkg and flow_vector_color_wheel_core.
`timescale 1ns / 100ps

class color_scoreboard;
	logic [23:0] color_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// note an accepted vector's expected color
	function void note_vector(logic [23:0] rgb);
		color_q.push_back(rgb);
	endfunction

	// compare one output color with the oldest expectation
	function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [23:0] exp_rgb;
		if (color_q.size() == 0) begin
			$display("%0t: unexpected color %0d %0d %0d", $time, r, g, b);
			errors++;
			return;
		end
		exp_rgb = color_q.pop_front();
		if (exp_rgb[23:16] !== r) begin
			$display("%0t: red expected %0d actual %0d", $time, exp_rgb[23:16], r);
			errors++;
		end
		if (exp_rgb[15:8] !== g) begin
			$display("%0t: green expected %0d actual %0d", $time, exp_rgb[15:8], g);
			errors++;
		end
		if (exp_rgb[7:0] !== b) begin
			$display("%0t: blue expected %0d actual %0d", $time, exp_rgb[7:0], b);
			errors++;
		end
	endfunction
endclass

module flow_vector_color_wheel_core_test;
	import fvcw_pkg::*;

	localparam int LATENCY = 57;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] flow_x;
	logic signed [15:0] flow_y;
	logic flow_valid;
	logic out_valid;
	logic out_ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	color_scoreboard sb;
	logic [15:0] motion_cfg;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_recv;
	int quiet_cycles;

	flow_vector_color_wheel_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.flow_x(flow_x), .flow_y(flow_y), .flow_valid(flow_valid),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// wheel entry channel value, computed from the segment formulas
	function automatic logic [7:0] wheel_chan(int k, int ch);
		int i, r, g, b;
		if (k < 15) begin
			i = k; r = 255; g = 255 * i / 15; b = 0;
		end else if (k < 21) begin
			i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
		end else if (k < 25) begin
			i = k - 21; r = 0; g = 255; b = 255 * i / 4;
		end else if (k < 36) begin
			i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
		end else if (k < 49) begin
			i = k - 36; r = 255 * i / 13; g = 0; b = 255;
		end else begin
			i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
		end
		return (ch == 0) ? r[7:0] : ((ch == 1) ? g[7:0] : b[7:0]);
	endfunction

	// floor shift of a signed value
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// CORDIC direction in 2^-32 turns
	function automatic logic [31:0] flow_angle(longint x, longint y);
		logic [31:0] z;
		longint xs, ys;
		z = '0;
		if (y == 0) return (x < 0) ? HALF_TURN : 32'd0;
		if (x < 0) begin
			x = -x; y = -y; z = HALF_TURN;
		end
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
			end
		end
		return z;
	endfunction

	function automatic logic [23:0] flow_color(logic [15:0] fx, logic [15:0] fy, logic ok);
		longint x, y;
		longint unsigned m, s, m2, r, p, f, c, d, v;
		logic [7:0] chan[3];
		int k0, k1;
		bit in_unit;
		if (!ok) return 24'd0;
		x = $signed(fx);
		y = $signed(fy);
		m = (motion_cfg == 0) ? 1 : motion_cfg;
		s = x * x + y * y;
		m2 = m * m;
		in_unit = s <= m2;
		r = in_unit ? int_sqrt((s << 32) / m2) : 0;
		p = longint'(flow_angle(x, y)) * 54;
		k0 = int'(p >> 32);
		k1 = (k0 + 1) % NCOLS;
		f = (p >> 16) & 64'hFFFF;
		for (int ch = 0; ch < 3; ch++) begin
			c = wheel_chan(k0, ch) * (65536 - f) + wheel_chan(k1, ch) * f;
			if (in_unit) begin
				d = 255 * 65536 - c;
				v = 255 - ((r * d + 64'hFFFF_FFFF) >> 32);
			end else begin
				v = (3 * c) >> 18;
			end
			chan[ch] = v[7:0];
		end
		return {chan[0], chan[1], chan[2]};
	endfunction

	// drive one vector and hold it until transfer
	task automatic send_vector(logic [15:0] fx, logic [15:0] fy, logic ok);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		flow_x <= fx;
		flow_y <= fy;
		flow_valid <= ok;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_vector(flow_color(fx, fy, ok));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.color_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	// write max_motion while idle
	task automatic write_motion(logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		motion_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_vectors(int count);
		logic [15:0] fx, fy;
		int scale;
		for (int n = 0; n < count; n++) begin
			scale = $urandom_range(3);
			fx = $urandom;
			fy = $urandom;
			// mostly small vectors so both radius branches occur
			if (scale != 0) begin
				fx = $signed(fx) >>> (4 + 3 * scale);
				fy = $signed(fy) >>> (4 + 3 * scale);
			end
			if ($urandom_range(9) == 0) fy = 16'd0;
			send_vector(fx, fy, $urandom_range(15) != 0);
		end
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_recv)
			out_ready <= 1'b0;
		else
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_color(red, green, blue);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		sb = new();
		motion_cfg = 16'd256;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_recv = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		flow_x = '0;
		flow_y = '0;
		flow_valid = 1'b0;
		out_ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero vector, axes, extremes, invalid
		send_vector(16'd0, 16'd0, 1'b1);
		send_vector(16'd100, 16'd0, 1'b1);
		send_vector(-16'sd100, 16'd0, 1'b1);
		send_vector(16'd0, 16'd100, 1'b1);
		send_vector(16'd0, -16'sd100, 1'b1);
		send_vector(16'd256, 16'd0, 1'b1);
		send_vector(16'd181, 16'd181, 1'b1);
		send_vector(16'h7FFF, 16'h7FFF, 1'b1);
		send_vector(16'h8000, 16'h8000, 1'b1);
		send_vector(16'h8000, 16'h7FFF, 1'b1);
		send_vector(16'h7FFF, 16'h8000, 1'b1);
		send_vector(16'hFFFF, 16'hFFFF, 1'b1);
		send_vector(16'h8000, 16'd0, 1'b1);
		send_vector(16'h7FFF, 16'h7FFF, 1'b0);
		send_vector(-16'sd50, 16'd1, 1'b1);
		send_vector(-16'sd50, -16'sd1, 1'b1);
		write_motion(16'd0);
		send_vector(16'd1, 16'd0, 1'b1);
		send_vector(16'd1, 16'd1, 1'b1);
		send_vector(16'd0, 16'd0, 1'b1);
		write_motion(16'hFFFF);
		send_vector(16'h8000, 16'h8000, 1'b1);
		send_vector(16'h7FFF, 16'h1234, 1'b1);
		send_vector(16'd0, 16'h8000, 1'b1);

		// random phases across settings and idling patterns
		write_motion(16'd1);
		send_idle_pct = 29;
		recv_idle_pct = 83;
		random_vectors(100);
		write_motion(16'd300);
		send_idle_pct = 83;
		recv_idle_pct = 29;
		random_vectors(100);
		write_motion(16'd40);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_vectors(100);

		// long receiver hold-off while vectors keep coming
		fork
			begin
				hold_recv = 1'b1;
				repeat (300) @(negedge clk);
				hold_recv = 1'b0;
			end
			random_vectors(120);
		join
		// sender pause until all colors have come
		drain();
		write_motion(16'd4096);
		random_vectors(30);
		drain();

		if (sb.errors == 0 && sb.color_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

FILE: sim.f
rtl/fvcw_pkg.sv
rtl/fvcw_cell.sv
rtl/fvcw_color.sv
rtl/flow_vector_color_wheel_core.sv
test/flow_vector_color_wheel_core_test.sv
